@@ sv/bts_pkg.sv @@
// Package with the shared types and constants of the bilinear texture sampler.
`timescale 1ns / 1ps
`default_nettype none

package bts_pkg;

    // Largest texture side and the widths that follow from the fixed field widths.
    localparam int MAX_SIDE = 256;
    localparam int SIDE_W   = 8;
    localparam int FRAC_W   = 16;
    localparam int COORD_W  = 18;
    localparam int UCL_W    = FRAC_W + 1;
    localparam int POS_W    = SIDE_W + FRAC_W;
    localparam int SIZE_W   = 9;
    localparam int CHAN_W   = 8;
    localparam int OUT_W    = 16;
    localparam int HSUM_W   = 25;
    localparam int VSUM_W   = 41;
    localparam int BANK_AW  = 2 * (SIDE_W - 1);
    localparam int NBANK    = 4;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = 2;
    localparam int QCNT_W   = 3;

    // Command codes of an input item.
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Register indexes on the configuration port.
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Size minus one, the largest position, in each direction, derived from the registers.
    typedef struct packed {
        logic [SIDE_W-1:0] wm1;
        logic [SIDE_W-1:0] hm1;
    } t_size;

    // One classified item held in the queue between the front and the back.
    typedef struct packed {
        logic              cmd;
        logic [SIDE_W-1:0] tex_x;
        logic [SIDE_W-1:0] tex_y;
        logic [3*CHAN_W-1:0] rgb;
        logic [POS_W-1:0]  px;
        logic [POS_W-1:0]  py;
    } t_entry;

endpackage

`default_nettype wire

@@ sv/bts_if.sv @@
// Handshake interfaces for the input items and the result items of the sampler.
`timescale 1ns / 1ps
`default_nettype none

interface bts_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [7:0]  tex_x;
    logic [7:0]  tex_y;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic signed [17:0] coord_u;
    logic signed [17:0] coord_v;

    modport source (output valid, command, tex_x, tex_y, red_in, green_in, blue_in,
                    coord_u, coord_v, input ready);
    modport sink (input valid, command, tex_x, tex_y, red_in, green_in, blue_in,
                  coord_u, coord_v, output ready);
endinterface

interface bts_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;

    modport source (output valid, red_out, green_out, blue_out, input ready);
    modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

`default_nettype wire

@@ sv/bts_front.sv @@
// Front end: accepts items, clamps and scales the coordinates, and hands them to the queue.
`timescale 1ns / 1ps
`default_nettype none

module bts_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    bts_in_if.sink               i_smp,
    input  wire bts_pkg::t_size  i_size,
    output logic                 o_push,
    output bts_pkg::t_entry      o_entry,
    input  wire logic            i_full
);

    logic                         r_v;
    bts_pkg::t_entry              r_e;
    bts_pkg::t_entry              n_e;
    logic [bts_pkg::UCL_W-1:0]    u_c;
    logic [bts_pkg::UCL_W-1:0]    v_c;

    // Clamp a signed coordinate to the range zero to one.
    function automatic logic [bts_pkg::UCL_W-1:0] clamp_c(
        input logic [bts_pkg::COORD_W-1:0] c);
        logic [bts_pkg::UCL_W-1:0] r;
        if (c[bts_pkg::COORD_W-1]) begin
            r = '0;
        end else if (c[bts_pkg::FRAC_W] && (c[bts_pkg::FRAC_W-1:0] != '0)) begin
            r = {1'b1, {bts_pkg::FRAC_W{1'b0}}};
        end else begin
            r = c[bts_pkg::UCL_W-1:0];
        end
        return r;
    endfunction

    assign u_c = clamp_c(i_smp.coord_u);
    assign v_c = clamp_c(i_smp.coord_v);

    // Classify and scale the incoming item.
    always_comb begin
        n_e.cmd   = i_smp.command;
        n_e.tex_x = i_smp.tex_x;
        n_e.tex_y = i_smp.tex_y;
        n_e.rgb   = {i_smp.red_in, i_smp.green_in, i_smp.blue_in};
        n_e.px    = bts_pkg::POS_W'(u_c * i_size.wm1);
        n_e.py    = bts_pkg::POS_W'(v_c * i_size.hm1);
    end

    assign o_push      = r_v && !i_full;
    assign o_entry     = r_e;
    assign i_smp.ready = !r_v || !i_full;

    // The front register holds one item until the queue takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_smp.ready) begin
            r_v <= i_smp.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_smp.ready && i_smp.valid) begin
            r_e <= n_e;
        end
    end

endmodule

`default_nettype wire

@@ sv/bts_fifo.sv @@
// Short queue of classified items between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module bts_fifo (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire bts_pkg::t_entry  i_entry,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output bts_pkg::t_entry       o_head
);

    bts_pkg::t_entry               r_mem [bts_pkg::QDEPTH];
    logic [bts_pkg::QPTR_W-1:0]    r_wp;
    logic [bts_pkg::QPTR_W-1:0]    r_rp;
    logic [bts_pkg::QCNT_W-1:0]    r_cnt;

    assign o_full  = (r_cnt == bts_pkg::QCNT_W'(bts_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

endmodule

`default_nettype wire

@@ sv/bts_back.sv @@
// Back end: texel store in four banks, fetch of the four neighbors and the bilinear blend.
`timescale 1ns / 1ps
`default_nettype none

module bts_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire bts_pkg::t_size   i_size,
    input  wire logic             i_empty,
    input  wire bts_pkg::t_entry  i_head,
    output logic                  o_pop,
    bts_out_if.source             o_res
);

    localparam int SW = bts_pkg::SIDE_W;
    localparam int FW = bts_pkg::FRAC_W;
    localparam int CW = bts_pkg::CHAN_W;

    logic [3*CW-1:0]              r_mem [bts_pkg::NBANK][2**bts_pkg::BANK_AW];
    logic [3*CW-1:0]              r_rd  [bts_pkg::NBANK];
    logic [bts_pkg::BANK_AW-1:0]  raddr [bts_pkg::NBANK];

    logic                         en;
    logic [SW-1:0]                x0, y0, x1, y1;
    logic [SW-1:0]                rcol [2];
    logic [SW-1:0]                rrow [2];

    // Stage one: neighbor parities and fractions, read data in r_rd.
    logic                         r1_v;
    logic                         r1_x0p, r1_x1p, r1_y0p, r1_y1p;
    logic [FW-1:0]                r1_dx, r1_dy;

    // Stage two: horizontal blends of the two rows.
    logic                         r2_v;
    logic [bts_pkg::HSUM_W-1:0]   r2_h0 [3];
    logic [bts_pkg::HSUM_W-1:0]   r2_h1 [3];
    logic [FW-1:0]                r2_dy;

    // Stage three: the result register.
    logic                         r3_v;
    logic [bts_pkg::OUT_W-1:0]    r3_c [3];

    logic [3*CW-1:0]              t [4];
    logic [FW:0]                  wx0, wy0;
    logic [bts_pkg::HSUM_W-1:0]   n_h0 [3];
    logic [bts_pkg::HSUM_W-1:0]   n_h1 [3];
    logic [bts_pkg::VSUM_W-1:0]   acc  [3];

    assign en    = !r3_v || o_res.ready;
    assign o_pop = en && !i_empty;

    // Integer positions of the four neighbors, the second one clamped to the edge.
    always_comb begin
        x0 = i_head.px[bts_pkg::POS_W-1:FW];
        y0 = i_head.py[bts_pkg::POS_W-1:FW];
        x1 = (({1'b0, x0} + 1'b1) < {1'b0, i_size.wm1}) ? SW'(x0 + 1'b1) : i_size.wm1;
        y1 = (({1'b0, y0} + 1'b1) < {1'b0, i_size.hm1}) ? SW'(y0 + 1'b1) : i_size.hm1;
        for (int p = 0; p < 2; p++) begin
            rcol[p] = (x0[0] == 1'(p)) ? x0 : x1;
            rrow[p] = (y0[0] == 1'(p)) ? y0 : y1;
        end
        // Bank index is {row parity, column parity}.
        for (int b = 0; b < bts_pkg::NBANK; b++) begin
            raddr[b] = {rrow[b/2][SW-1:1], rcol[b%2][SW-1:1]};
        end
    end

    // Texel banks: one write and one read per bank and cycle.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int b = 0; b < bts_pkg::NBANK; b++) begin
                if (i_head.cmd == bts_pkg::CMD_WRITE &&
                    {i_head.tex_y[0], i_head.tex_x[0]} == 2'(b)) begin
                    r_mem[b][{i_head.tex_y[SW-1:1], i_head.tex_x[SW-1:1]}] <= i_head.rgb;
                end
            end
        end
        if (en) begin
            for (int b = 0; b < bts_pkg::NBANK; b++) begin
                r_rd[b] <= r_mem[b][raddr[b]];
            end
        end
    end

    // Stage one register.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_x0p <= x0[0];
            r1_x1p <= x1[0];
            r1_y0p <= y0[0];
            r1_y1p <= y1[0];
            r1_dx  <= i_head.px[FW-1:0];
            r1_dy  <= i_head.py[FW-1:0];
        end
    end

    // Pick the four texels and blend along x.
    always_comb begin
        t[0] = r_rd[{r1_y0p, r1_x0p}];
        t[1] = r_rd[{r1_y0p, r1_x1p}];
        t[2] = r_rd[{r1_y1p, r1_x0p}];
        t[3] = r_rd[{r1_y1p, r1_x1p}];
        wx0  = (FW+1)'(2**FW) - {1'b0, r1_dx};
        for (int c = 0; c < 3; c++) begin
            n_h0[c] = bts_pkg::HSUM_W'(t[0][CW*(2-c) +: CW] * wx0)
                    + bts_pkg::HSUM_W'(t[1][CW*(2-c) +: CW] * r1_dx);
            n_h1[c] = bts_pkg::HSUM_W'(t[2][CW*(2-c) +: CW] * wx0)
                    + bts_pkg::HSUM_W'(t[3][CW*(2-c) +: CW] * r1_dx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_h0 <= n_h0;
            r2_h1 <= n_h1;
            r2_dy <= r1_dy;
        end
    end

    // Blend along y and truncate to byte units with eight fraction bits.
    always_comb begin
        wy0 = (FW+1)'(2**FW) - {1'b0, r2_dy};
        for (int c = 0; c < 3; c++) begin
            acc[c] = bts_pkg::VSUM_W'(r2_h0[c] * wy0) + bts_pkg::VSUM_W'(r2_h1[c] * r2_dy);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r3_c[c] <= acc[c][2*FW-CW +: bts_pkg::OUT_W];
            end
        end
    end

    // Valid bits: only sample items travel as results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (en) begin
            r1_v <= o_pop && (i_head.cmd == bts_pkg::CMD_SAMPLE);
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    assign o_res.valid     = r3_v;
    assign o_res.red_out   = r3_c[0];
    assign o_res.green_out = r3_c[1];
    assign o_res.blue_out  = r3_c[2];

endmodule

`default_nettype wire

@@ sv/bilinear_texture_sampler.sv @@
// Top level of the bilinear texture sampler with its configuration registers.
`timescale 1ns / 1ps
`default_nettype none

// Bilinear texture sampler with clamp-to-edge addressing. Write items fill a
// 256 x 256 RGB texel store, sample items return one blended RGB result each
// in byte units with eight fraction bits. One item is taken every cycle
// unless the queue is full. The store is split into four banks by column
// and row parity so the four neighbors are read in the same cycle, and a
// four-entry queue between the front end and the blend pipeline absorbs
// output stalls. Set tex_width and tex_height over the register port while
// the block is idle, and write every texel a sample can touch before
// sampling it.
module bilinear_texture_sampler (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    bts_in_if.sink           i_smp,
    bts_out_if.source        o_res,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [bts_pkg::SIZE_W-1:0] r_width;
    logic [bts_pkg::SIZE_W-1:0] r_height;
    bts_pkg::t_size             size;
    logic                       push, full, pop, empty;
    bts_pkg::t_entry            entry, head;

    // Size minus one, with zero taken as one and large sizes saturated.
    function automatic logic [bts_pkg::SIDE_W-1:0] side_m1(
        input logic [bts_pkg::SIZE_W-1:0] s);
        logic [bts_pkg::SIDE_W-1:0] r;
        if (s == '0) begin
            r = '0;
        end else if (s > bts_pkg::SIZE_W'(bts_pkg::MAX_SIDE)) begin
            r = bts_pkg::SIDE_W'(bts_pkg::MAX_SIDE - 1);
        end else begin
            r = bts_pkg::SIDE_W'(s - 1'b1);
        end
        return r;
    endfunction

    assign size.wm1 = side_m1(r_width);
    assign size.hm1 = side_m1(r_height);

    // Register port.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= bts_pkg::SIZE_W'(1);
            r_height <= bts_pkg::SIZE_W'(1);
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                bts_pkg::REG_WIDTH:  r_width  <= pwdata[bts_pkg::SIZE_W-1:0];
                bts_pkg::REG_HEIGHT: r_height <= pwdata[bts_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            bts_pkg::REG_WIDTH:  prdata = {{(32-bts_pkg::SIZE_W){1'b0}}, r_width};
            bts_pkg::REG_HEIGHT: prdata = {{(32-bts_pkg::SIZE_W){1'b0}}, r_height};
            default:             prdata = '0;
        endcase
    end

    bts_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (i_smp),
        .i_size  (size),
        .o_push  (push),
        .o_entry (entry),
        .i_full  (full)
    );

    bts_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head)
    );

    bts_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_size  (size),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

@@ test/tb_bilinear_texture_sampler.sv @@
// Testbench for the bilinear texture sampler: texel writes, samples and size settings.
`timescale 1ns / 1ps

module tb_bilinear_texture_sampler;

    // One input item as the driver presents it.
    typedef struct {
        logic              command;
        logic [7:0]        tex_x;
        logic [7:0]        tex_y;
        logic [7:0]        red_in;
        logic [7:0]        green_in;
        logic [7:0]        blue_in;
        logic signed [17:0] coord_u;
        logic signed [17:0] coord_v;
    } t_item;

    typedef struct {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
    } t_color;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    bts_in_if  smp_if ();
    bts_out_if res_if ();

    bilinear_texture_sampler u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_if.sink),
        .o_res   (res_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #1 i_clk = ~i_clk;

    // Predictor state: its own texel copy and size registers.
    logic [23:0] texels [0:65535];
    logic [8:0]  side_w;
    logic [8:0]  side_h;

    t_item  pending_items [$];
    t_color expected_colors [$];
    int     error_count = 0;
    int     cycle_count = 0;
    bit     hold_off = 1'b0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    function automatic logic [8:0] eff_side(input logic [8:0] s);
        if (s == 0) return 9'd1;
        if (s > bts_pkg::MAX_SIDE) return 9'(bts_pkg::MAX_SIDE);
        return s;
    endfunction

    function automatic logic [16:0] clamp_unit(input logic signed [17:0] c);
        if (c < 0) return 17'd0;
        if (c > 18'sd65536) return 17'd65536;
        return 17'(c);
    endfunction

    // Blends the four neighbors of the sample point in exact arithmetic.
    function automatic t_color blend_sample(input t_item it);
        logic [8:0]  w, h;
        logic [31:0] px, py, x0, y0, x1, y1, dx, dy;
        logic [63:0] wt [4];
        logic [23:0] t [4];
        logic [63:0] acc;
        logic [15:0] ch [3];
        t_color      c;
        w = eff_side(side_w);
        h = eff_side(side_h);
        px = clamp_unit(it.coord_u) * (w - 1);
        py = clamp_unit(it.coord_v) * (h - 1);
        x0 = px >> 16;
        y0 = py >> 16;
        dx = px & 32'hFFFF;
        dy = py & 32'hFFFF;
        x1 = (x0 + 1 < w - 1) ? x0 + 1 : w - 1;
        y1 = (y0 + 1 < h - 1) ? y0 + 1 : h - 1;
        t[0] = texels[y0 * 256 + x0];
        t[1] = texels[y0 * 256 + x1];
        t[2] = texels[y1 * 256 + x0];
        t[3] = texels[y1 * 256 + x1];
        wt[0] = 64'(65536 - dx) * 64'(65536 - dy);
        wt[1] = 64'(dx) * 64'(65536 - dy);
        wt[2] = 64'(65536 - dx) * 64'(dy);
        wt[3] = 64'(dx) * 64'(dy);
        for (int k = 0; k < 3; k++) begin
            acc = 0;
            for (int j = 0; j < 4; j++)
                acc += 64'((t[j] >> (16 - 8 * k)) & 8'hFF) * wt[j];
            ch[k] = acc[39:24];
        end
        c.red = ch[0];
        c.green = ch[1];
        c.blue = ch[2];
        return c;
    endfunction

    // Driver: pops pending items and holds each until accepted.
    int  send_gap = 0;
    bit  have_item = 1'b0;
    initial begin
        smp_if.valid = 1'b0;
        smp_if.command = bts_pkg::CMD_WRITE;
        smp_if.tex_x = '0;
        smp_if.tex_y = '0;
        smp_if.red_in = '0;
        smp_if.green_in = '0;
        smp_if.blue_in = '0;
        smp_if.coord_u = '0;
        smp_if.coord_v = '0;
        res_if.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        t_item it;
        bit    accepted;
        accepted = smp_if.valid && smp_if.ready && i_rst_n;
        if (accepted) begin
            it.command = smp_if.command;
            it.tex_x = smp_if.tex_x;
            it.tex_y = smp_if.tex_y;
            it.red_in = smp_if.red_in;
            it.green_in = smp_if.green_in;
            it.blue_in = smp_if.blue_in;
            it.coord_u = smp_if.coord_u;
            it.coord_v = smp_if.coord_v;
            if (it.command == bts_pkg::CMD_WRITE) begin
                texels[{it.tex_y, it.tex_x}] = {it.red_in, it.green_in, it.blue_in};
            end else begin
                expected_colors.push_back(blend_sample(it));
            end
        end
        if (!i_rst_n || (smp_if.valid && !accepted)) begin
            // Keep the current item on the bus.
        end else if (send_gap > 0) begin
            send_gap--;
            smp_if.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
            it = pending_items.pop_front();
            smp_if.valid <= 1'b1;
            smp_if.command <= it.command;
            smp_if.tex_x <= it.tex_x;
            smp_if.tex_y <= it.tex_y;
            smp_if.red_in <= it.red_in;
            smp_if.green_in <= it.green_in;
            smp_if.blue_in <= it.blue_in;
            smp_if.coord_u <= it.coord_u;
            smp_if.coord_v <= it.coord_v;
            send_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
        end else begin
            smp_if.valid <= 1'b0;
        end
    end

    // Monitor: checks each accepted result and draws the receiver's stalls.
    int recv_gap = 0;
    always @(posedge i_clk) begin
        t_color e;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_colors.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                e = expected_colors.pop_front();
                if (res_if.red_out !== e.red)
                    report_mismatch($sformatf("red %h exp %h", res_if.red_out, e.red));
                if (res_if.green_out !== e.green)
                    report_mismatch($sformatf("green %h exp %h", res_if.green_out, e.green));
                if (res_if.blue_out !== e.blue)
                    report_mismatch($sformatf("blue %h exp %h", res_if.blue_out, e.blue));
            end
            recv_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
        end
        if (hold_off || recv_gap > 0) begin
            if (recv_gap > 0) recv_gap--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= i_rst_n;
        end
    end

    // Cycle limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > 400000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic idx, input logic [8:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == bts_pkg::REG_WIDTH) side_w = val;
        else side_h = val;
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || smp_if.valid || expected_colors.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic t_item texel_write(input int x, input int y, input logic [23:0] rgb);
        t_item it;
        it.command = bts_pkg::CMD_WRITE;
        it.tex_x = 8'(x);
        it.tex_y = 8'(y);
        {it.red_in, it.green_in, it.blue_in} = rgb;
        it.coord_u = 18'($urandom);
        it.coord_v = 18'($urandom);
        return it;
    endfunction

    function automatic t_item sample_at(input logic [17:0] u, input logic [17:0] v);
        t_item it;
        it.command = bts_pkg::CMD_SAMPLE;
        it.tex_x = 8'($urandom);
        it.tex_y = 8'($urandom);
        it.red_in = 8'($urandom);
        it.green_in = 8'($urandom);
        it.blue_in = 8'($urandom);
        it.coord_u = u;
        it.coord_v = v;
        return it;
    endfunction

    // Coordinates weighted toward the clamp edges and the inside of the range.
    function automatic logic [17:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 18'($urandom);
            1: return 18'h10000;
            2: return 18'($urandom_range(65537, 131071));
            default: return 18'($urandom_range(0, 65536));
        endcase
    endfunction

    // Fills the used area with random texels, then queues random samples.
    task automatic run_phase(input logic [8:0] w, input logic [8:0] h, input int n);
        int ew, eh;
        write_reg(bts_pkg::REG_WIDTH, w);
        write_reg(bts_pkg::REG_HEIGHT, h);
        ew = eff_side(w);
        eh = eff_side(h);
        for (int y = 0; y < eh; y++)
            for (int x = 0; x < ew; x++)
                pending_items.push_back(texel_write(x, y, 24'($urandom)));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0)
                pending_items.push_back(texel_write($urandom_range(0, ew - 1),
                    $urandom_range(0, eh - 1), 24'($urandom)));
            else
                pending_items.push_back(sample_at(rand_coord(), rand_coord()));
        end
        wait_idle();
    endtask

    initial begin
        for (int i = 0; i < 65536; i++) texels[i] = '0;
        side_w = 9'd1;
        side_h = 9'd1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extreme texels and coordinates on a 2 x 2 texture.
        write_reg(bts_pkg::REG_WIDTH, 9'd2);
        write_reg(bts_pkg::REG_HEIGHT, 9'd2);
        pending_items.push_back(texel_write(0, 0, 24'hFFFFFF));
        pending_items.push_back(texel_write(1, 0, 24'h000000));
        pending_items.push_back(texel_write(0, 1, 24'hFF00FF));
        pending_items.push_back(texel_write(1, 1, 24'h00FF00));
        pending_items.push_back(texel_write(255, 255, 24'hA5A5A5));
        pending_items.push_back(sample_at(18'h00000, 18'h00000));
        pending_items.push_back(sample_at(18'h10000, 18'h10000));
        pending_items.push_back(sample_at(18'h20000, 18'h3FFFF));
        pending_items.push_back(sample_at(18'h1FFFF, 18'h10001));
        pending_items.push_back(sample_at(18'h08000, 18'h08000));
        pending_items.push_back(sample_at(18'h0FFFF, 18'h00001));
        wait_idle();

        // Long receiver stall while the sender keeps offering samples.
        hold_off = 1'b1;
        for (int i = 0; i < 30; i++)
            pending_items.push_back(sample_at(rand_coord(), rand_coord()));
        repeat (200) @(posedge i_clk);
        hold_off = 1'b0;
        wait_idle();

        // Size settings: zero, small, odd, one, and a width above range.
        run_phase(9'd0, 9'd0, 20);
        run_phase(9'd3, 9'd5, 80);
        run_phase(9'd7, 9'd1, 40);
        run_phase(9'd1, 9'd6, 40);
        run_phase(9'd511, 9'd1, 60);

        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
